// ===== rtl/core/pswr_pkg.sv =====
// ----------------------------------------------------------------------------
// pswr_pkg
// shared types and constants of the per-source sliding window rate counter
// ----------------------------------------------------------------------------
package pswr_pkg;

    localparam int ID_W     = 32;
    localparam int TIME_W   = 64;
    localparam int WIN_W    = 32;
    localparam int OCNT_W   = 9;
    localparam int STAT_W   = 2;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd10000000;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_TBL_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RING_FULL = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic latch;     // capture input beat
        logic scan_clr;  // restart table scan
        logic scan_inc;  // next table entry
        logic alloc;     // claim current entry for new source
        logic set_full;  // table full, event dropped
        logic load;      // fetch head/count, compute window start
        logic rd;        // read ring slot at head
        logic expire;    // drop expired oldest time
        logic drop;      // ring full, drop oldest
        logic append;    // store new time, write back head/count
        logic out_load;  // move result to output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;       // current entry valid and id matches
        logic free;      // current entry invalid
        logic last;      // current entry is the last one
        logic cnt_zero;  // working count is zero
        logic cnt_full;  // working count equals ring depth
        logic older;     // read time is below window start
        logic out_busy;  // output register held by a stall
    } t_sts;

endpackage

// ===== rtl/core/per_source_sliding_window_rate.sv =====
// ----------------------------------------------------------------------------
// per_source_sliding_window_rate
// per-source event counter over a sliding time window
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_ready     i_source_id, i_event_time
//  result    out        o_out_valid / i_out_ready   o_result_source,
//                                                   o_event_count, o_status
//  config    in         i_cfg_wr_en                 i_cfg_wr_data (window_ticks)
//
//  one event at a time: latch, a linear scan of the table up to the source's
//  entry, load, then one ring memory read and one compare per expired time,
//  plus one more read and compare when times remain after the walk, since the
//  first time inside the window is checked too; a drop of the oldest when the
//  ring is full, then append; a dropped event on a full table scans all entries
//  reset (synchronous, active low) empties the source table; the ring memory
//  is not cleared, slots are only read once written
//  a result waiting in the output register does not block the next event;
//  the sequencer only waits at hand-off while that register is stalled
// ----------------------------------------------------------------------------
module per_source_sliding_window_rate #(
    parameter int NUM_SOURCES = 16,
    parameter int RING_DEPTH  = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic [pswr_pkg::WIN_W-1:0]     i_cfg_wr_data,
    // event input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [pswr_pkg::ID_W-1:0]      i_source_id,
    input  logic [pswr_pkg::TIME_W-1:0]    i_event_time,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pswr_pkg::ID_W-1:0]      o_result_source,
    output logic [pswr_pkg::OCNT_W-1:0]    o_event_count,
    output logic [pswr_pkg::STAT_W-1:0]    o_status
);
    import pswr_pkg::*;

    t_cmd cmd;   // sequencer commands
    t_sts sts;   // datapath flags

    // sequencer: scan, load, expiry walk, append, hand-off
    pswr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // table, ring memory, window start and output register
    pswr_dp #(
        .NUM_SOURCES (NUM_SOURCES),
        .RING_DEPTH  (RING_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_source_id     (i_source_id),
        .i_event_time    (i_event_time),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_result_source (o_result_source),
        .o_event_count   (o_event_count),
        .o_status        (o_status)
    );

endmodule

// ===== rtl/core/pswr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pswr_ctrl
// sequencer for lookup, expiry walk, append and result hand-off
// ----------------------------------------------------------------------------
module pswr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pswr_pkg::t_sts  i_sts,
    output pswr_pkg::t_cmd  o_cmd
);
    import pswr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_LOAD = 7'b0000100,
        S_RD   = 7'b0001000,
        S_CMP  = 7'b0010000,
        S_APP  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch    = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.free) begin
                    o_cmd.alloc = 1'b1;
                    n_state     = S_LOAD;
                end else if (i_sts.hit) begin
                    n_state = S_LOAD;
                end else if (i_sts.last) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_RD;
            end
            S_RD: begin
                if (i_sts.cnt_zero) begin
                    n_state = S_APP;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.older) begin
                    o_cmd.expire = 1'b1;
                    n_state      = S_RD;
                end else begin
                    n_state = S_APP;
                end
            end
            S_APP: begin
                if (i_sts.cnt_full) begin
                    o_cmd.drop = 1'b1;
                end else begin
                    o_cmd.append = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/core/pswr_dp.sv =====
// ----------------------------------------------------------------------------
// pswr_dp
// source table, ring memory, window arithmetic and output register
// ----------------------------------------------------------------------------
module pswr_dp #(
    parameter int NUM_SOURCES = 16,
    parameter int RING_DEPTH  = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [pswr_pkg::WIN_W-1:0]     i_cfg_wr_data,
    input  logic [pswr_pkg::ID_W-1:0]      i_source_id,
    input  logic [pswr_pkg::TIME_W-1:0]    i_event_time,
    input  pswr_pkg::t_cmd                 i_cmd,
    output pswr_pkg::t_sts                 o_sts,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [pswr_pkg::ID_W-1:0]      o_result_source,
    output logic [pswr_pkg::OCNT_W-1:0]    o_event_count,
    output logic [pswr_pkg::STAT_W-1:0]    o_status
);
    import pswr_pkg::*;

    localparam int SIW    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int HW     = $clog2(RING_DEPTH);
    localparam int CW     = $clog2(RING_DEPTH + 1);
    localparam int MAW    = SIW + HW;
    localparam int MDEPTH = 2 ** MAW;

    // configuration
    logic [WIN_W-1:0]  r_window;

    // captured event
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_time;

    // source table, valid entries form a prefix since entries are never freed
    logic [NUM_SOURCES-1:0] r_valid;
    logic [ID_W-1:0]        r_ids  [NUM_SOURCES];
    logic [HW-1:0]          r_head [NUM_SOURCES];
    logic [CW-1:0]          r_cnt  [NUM_SOURCES];

    // working state of the current event
    logic [SIW-1:0]    r_scan;
    logic              r_full;
    logic [TIME_W-1:0] r_start;
    logic [HW-1:0]     r_wh;
    logic [CW-1:0]     r_wc;
    logic [CW-1:0]     r_old;
    logic [STAT_W-1:0] r_stat;

    // ring memory, one block of 2**HW slots per source
    logic [TIME_W-1:0] r_mem [MDEPTH];
    logic [TIME_W-1:0] r_rd_data;

    // output register
    logic              r_ovalid;
    logic [ID_W-1:0]   r_osrc;
    logic [OCNT_W-1:0] r_ocnt;
    logic [STAT_W-1:0] r_ostat;

    logic [HW-1:0]       head_inc;
    logic [CW:0]         app_sum;
    logic [HW-1:0]       app_slot;
    logic [TIME_W-1:0]   win_ext;
    logic [CW+OCNT_W-1:0] cnt_ext;
    logic                emit;

    assign head_inc = (r_wh == HW'(RING_DEPTH - 1)) ? '0 : r_wh + 1'b1;
    assign app_sum  = (CW + 1)'(r_wh) + (CW + 1)'(r_wc);
    assign app_slot = (app_sum >= (CW + 1)'(RING_DEPTH))
                    ? HW'(app_sum - (CW + 1)'(RING_DEPTH)) : HW'(app_sum);
    assign win_ext  = TIME_W'(r_window);
    assign cnt_ext  = {{OCNT_W{1'b0}}, r_wc};
    assign emit     = r_full || (r_wc != r_old) || (r_stat != ST_OK);

    assign o_sts.hit      = r_valid[r_scan] && (r_ids[r_scan] == r_id);
    assign o_sts.free     = !r_valid[r_scan];
    assign o_sts.last     = (r_scan == SIW'(NUM_SOURCES - 1));
    assign o_sts.cnt_zero = (r_wc == '0);
    assign o_sts.cnt_full = (r_wc == CW'(RING_DEPTH));
    assign o_sts.older    = (r_rd_data < r_start);
    assign o_sts.out_busy = r_ovalid && !i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (i_cmd.alloc) begin
                r_valid[r_scan] <= 1'b1;
                r_head[r_scan]  <= '0;
                r_cnt[r_scan]   <= '0;
            end
            if (i_cmd.append) begin
                r_head[r_scan] <= r_wh;
                r_cnt[r_scan]  <= r_wc + 1'b1;
            end
            if (i_cmd.out_load && emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_id   <= i_source_id;
            r_time <= i_event_time;
            r_full <= 1'b0;
        end
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + 1'b1;
        end
        if (i_cmd.set_full) begin
            r_full <= 1'b1;
        end
        if (i_cmd.alloc) begin
            r_ids[r_scan] <= r_id;
        end
        if (i_cmd.load) begin
            r_wh    <= r_head[r_scan];
            r_wc    <= r_cnt[r_scan];
            r_old   <= r_cnt[r_scan];
            r_stat  <= ST_OK;
            // window start saturates at zero
            r_start <= (r_time >= win_ext) ? r_time - win_ext : '0;
        end
        if (i_cmd.expire || i_cmd.drop) begin
            r_wh <= head_inc;
            r_wc <= r_wc - 1'b1;
        end
        if (i_cmd.drop) begin
            r_stat <= ST_RING_FULL;
        end
        if (i_cmd.append) begin
            r_wc <= r_wc + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_osrc  <= r_id;
            r_ocnt  <= r_full ? '0 : cnt_ext[OCNT_W-1:0];
            r_ostat <= r_full ? ST_TBL_FULL : r_stat;
        end
    end

    // ring memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[{r_scan, app_slot}] <= r_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[{r_scan, r_wh}];
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_result_source = r_osrc;
    assign o_event_count   = r_ocnt;
    assign o_status        = r_ostat;

endmodule

// ===== rtl/core/pswr_chk.sv =====
// ----------------------------------------------------------------------------
// pswr_chk
// port-level checks of the rate counter, bound to the top level
// ----------------------------------------------------------------------------
module pswr_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [pswr_pkg::OCNT_W-1:0]    o_event_count,
    input logic [pswr_pkg::STAT_W-1:0]    o_status
);
    import pswr_pkg::*;

    // stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // one event in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an event is in work");

    // dropped event reports an empty count
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_TBL_FULL) |-> (o_event_count == '0))
        else $error("table-full result with nonzero count");

    // after reset: idle and no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("block not idle after reset");

endmodule

bind per_source_sliding_window_rate pswr_chk u_pswr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_event_count (o_event_count),
    .o_status      (o_status)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the per-source sliding window rate counter beat by beat: a directed
// table (reset state, time extremes, window start at zero, out-of-order time,
// table fill and overflow), then randomized event streams under several
// window lengths. every accepted event runs through an in-bench model of the
// source table and time rings; result beats are matched against it in order.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pswr_pkg::*;

    localparam int NUM_SRC      = 16;
    localparam int RING_D       = 256;
    localparam int MAX_GAP      = 18;
    // worst event: full table scan, a read and a compare per expired time, drop
    localparam int DRAIN_CYCLES = 600;
    localparam int HOLD_CYCLES  = 3000;
    localparam int MAX_SHOWN    = 10;
    localparam int BURST_SRC    = 4;

    // one result beat
    typedef struct packed {
        logic [ID_W-1:0]   src;
        logic [OCNT_W-1:0] cnt;
        logic [STAT_W-1:0] st;
    } rate_beat_t;

    // one row of the directed table
    typedef struct {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
        bit                typed;      // expectation written in the row
        bit                typed_has;  // row expects a result beat
        rate_beat_t        typed_beat;
    } event_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [WIN_W-1:0]     i_cfg_wr_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [ID_W-1:0]      i_source_id;
    logic [TIME_W-1:0]    i_event_time;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [ID_W-1:0]      o_result_source;
    logic [OCNT_W-1:0]    o_event_count;
    logic [STAT_W-1:0]    o_status;

    // shadow of the block: source table, time rings, window length
    logic [ID_W-1:0]      src_tag      [NUM_SRC];
    bit                   src_live     [NUM_SRC];
    logic [TIME_W-1:0]    stamp_ring   [NUM_SRC][RING_D];
    int unsigned          oldest_slot  [NUM_SRC];
    int unsigned          stamp_count  [NUM_SRC];
    logic [WIN_W-1:0]     win_len;

    // per-source time cursor for well-formed random streams
    logic [TIME_W-1:0]    stamp_cursor [NUM_SRC];

    rate_beat_t           rate_expect_q[$];
    event_row_t           dir_rows[$];
    int                   mismatch_count;
    bit                   burst;          // both sides run without idling
    int                   rx_hold_cycles; // long receiver hold-off request

    per_source_sliding_window_rate #(
        .NUM_SOURCES (NUM_SRC),
        .RING_DEPTH  (RING_D)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_source_id     (i_source_id),
        .i_event_time    (i_event_time),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_source (o_result_source),
        .o_event_count   (o_event_count),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // append an expected beat at the tail of the queue
    function automatic void enqueue_beat(input rate_beat_t b);
        rate_expect_q.insert(rate_expect_q.size(), b);
    endfunction

    // append a row at the end of the directed table
    function automatic void add_row(input event_row_t row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // event counting on the shadow state; returns 1 when a beat is due
    function automatic bit count_in_window(input logic [ID_W-1:0] id,
                                           input logic [TIME_W-1:0] stamp,
                                           output rate_beat_t beat);
        int          slot;
        int unsigned head;
        int unsigned cnt;
        int unsigned prev;
        logic [TIME_W-1:0] wstart;
        logic [STAT_W-1:0] st;
        slot = -1;
        // known source first, else lowest free entry
        for (int s = 0; s < NUM_SRC; s++) begin
            if (src_live[s] && src_tag[s] == id) begin
                slot = s;
                break;
            end
        end
        if (slot < 0) begin
            for (int s = 0; s < NUM_SRC; s++) begin
                if (!src_live[s]) begin
                    slot           = s;
                    src_live[s]    = 1'b1;
                    src_tag[s]     = id;
                    oldest_slot[s] = 0;
                    stamp_count[s] = 0;
                    break;
                end
            end
        end
        beat.src = id;
        // table full: event dropped
        if (slot < 0) begin
            beat.cnt = '0;
            beat.st  = ST_TBL_FULL;
            return 1'b1;
        end
        head = oldest_slot[slot];
        cnt  = stamp_count[slot];
        prev = cnt;
        // window start saturates at zero
        wstart = (stamp >= TIME_W'(win_len)) ? stamp - TIME_W'(win_len) : '0;
        // expire from the oldest, stop at the first time inside the window
        while (cnt > 0 && stamp_ring[slot][head] < wstart) begin
            head = (head + 1) % RING_D;
            cnt--;
        end
        st = ST_OK;
        // ring still full: oldest goes
        if (cnt == RING_D) begin
            head = (head + 1) % RING_D;
            cnt--;
            st = ST_RING_FULL;
        end
        stamp_ring[slot][(head + cnt) % RING_D] = stamp;
        cnt++;
        oldest_slot[slot] = head;
        stamp_count[slot] = cnt;
        beat.cnt = OCNT_W'(cnt);
        beat.st  = st;
        return !(cnt == prev && st == ST_OK);
    endfunction

    // next time of a source: mostly forward, at times back in time
    function automatic logic [TIME_W-1:0] next_stamp(input int s);
        int                pick;
        logic [TIME_W-1:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            // out of order, cursor left where it was
            return stamp_cursor[s] - TIME_W'($urandom_range(0, win_len));
        end
        else if (pick < 30) begin
            step = '0;
        end
        else if (pick < 60) begin
            step = TIME_W'($urandom_range(0, win_len / 8 + 1));
        end
        else if (pick < 85) begin
            // around one window length, hits the strict compare
            step = TIME_W'(win_len) + TIME_W'($urandom_range(0, 4));
            step = (step >= 2) ? step - 2 : '0;
        end
        else begin
            step = {$urandom, $urandom} >> $urandom_range(8, 40);
        end
        stamp_cursor[s] += step;
        return stamp_cursor[s];
    endfunction

    function automatic event_row_t mk_row(input logic [ID_W-1:0] id,
                                          input logic [TIME_W-1:0] stamp,
                                          input bit typed, input bit has,
                                          input logic [OCNT_W-1:0] cnt,
                                          input logic [STAT_W-1:0] st);
        event_row_t row;
        row.id         = id;
        row.stamp      = stamp;
        row.typed      = typed;
        row.typed_has  = has;
        row.typed_beat = '{src: id, cnt: cnt, st: st};
        return row;
    endfunction

    // offer one event beat, return at the edge where it is taken
    task automatic offer_event(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] stamp);
        int gap;
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_source_id  <= id;
        i_event_time <= stamp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic post_event(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] stamp);
        rate_beat_t beat;
        offer_event(id, stamp);
        if (count_in_window(id, stamp, beat)) enqueue_beat(beat);
    endtask

    task automatic wait_drained();
        while (rate_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // window change only with the block idle
    task automatic write_window(input logic [WIN_W-1:0] w);
        i_in_valid <= 1'b0;
        wait_drained();
        // an event with no result may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        win_len = w;
    endtask

    // random mix over the table sources, a few strangers that hit a full table
    task automatic run_mixed(input int n, input bit keep_busy);
        int s;
        for (int k = 0; k < n; k++) begin
            if (k % 25 == 0) burst = keep_busy || ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 5) begin
                post_event($urandom, {$urandom, $urandom});
            end
            else begin
                // a few sources get most events so their rings grow
                s = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NUM_SRC - 1)
                                                : $urandom_range(0, 3);
                post_event(src_tag[s], next_stamp(s));
            end
        end
        burst = 1'b0;
    endtask

    // result side: random stalls, long hold-off on request, in-order check
    initial begin
        int         gap;
        rate_beat_t got;
        rate_beat_t want;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else begin
                gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got = '{src: o_result_source, cnt: o_event_count, st: o_status};
            if (rate_expect_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected result beat: src %h count %0d status %0d",
                             got.src, got.cnt, got.st);
            end
            else begin
                want = rate_expect_q.pop_front();
                if (got.src !== want.src || got.cnt !== want.cnt || got.st !== want.st) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("result beat mismatch: want src %h count %0d status %0d, got src %h count %0d status %0d",
                                 want.src, want.cnt, want.st, got.src, got.cnt, got.st);
                end
            end
        end
    end

    // stimulus
    initial begin
        rate_beat_t beat;
        bit         has;
        logic [ID_W-1:0] id_a;
        logic [ID_W-1:0] id_b;
        logic [ID_W-1:0] id_c;

        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        i_in_valid     <= 1'b0;
        i_source_id    <= '0;
        i_event_time   <= '0;
        mismatch_count = 0;
        burst          = 1'b0;
        rx_hold_cycles = 0;
        win_len        = WINDOW_RESET;
        foreach (src_live[s]) begin
            src_live[s]    = 1'b0;
            src_tag[s]     = '0;
            oldest_slot[s] = 0;
            stamp_count[s] = 0;
        end

        id_a = 32'h1234_5678;
        id_b = 32'hFFFF_FFFF;
        id_c = 32'h0000_0000;

        // directed table, window at its reset length
        add_row(mk_row(id_a, 64'd0, 1, 1, 9'd1, ST_OK));
        add_row(mk_row(id_a, 64'd0, 0, 0, '0, ST_OK));
        // latest possible time expires both
        add_row(mk_row(id_a, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, '0, ST_OK));
        // back in time: oldest is inside the window, nothing expires
        add_row(mk_row(id_a, 64'd0, 0, 0, '0, ST_OK));
        // time below the window length, start pinned at zero
        add_row(mk_row(id_b, 64'd5, 1, 1, 9'd1, ST_OK));
        // one out, one in: count unchanged, no beat
        add_row(mk_row(id_b, 64'd10_000_006, 0, 0, '0, ST_OK));
        add_row(mk_row(id_b, 64'd9_999_999, 0, 0, '0, ST_OK));
        add_row(mk_row(id_c, 64'h8000_0000_0000_0000, 1, 1, 9'd1, ST_OK));
        // fill the remaining table entries
        for (int k = 0; k < NUM_SRC - 3; k++)
            add_row(mk_row(32'h1 << k, 64'(k) * 64'd1000, 1, 1, 9'd1, ST_OK));
        // one source too many
        add_row(mk_row(32'hDEAD_BEEF, 64'd1, 1, 1, 9'd0, ST_TBL_FULL));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            offer_event(dir_rows[i].id, dir_rows[i].stamp);
            has = count_in_window(dir_rows[i].id, dir_rows[i].stamp, beat);
            if (dir_rows[i].typed) begin
                if (dir_rows[i].typed_has) enqueue_beat(dir_rows[i].typed_beat);
            end
            else if (has) begin
                enqueue_beat(beat);
            end
        end

        // shortest window: almost everything expires
        write_window(32'd1);
        foreach (stamp_cursor[s]) stamp_cursor[s] = {$urandom, $urandom};
        run_mixed(150, 1'b0);

        // longest window: one source runs its ring full
        write_window(32'hFFFF_FFFF);
        for (int k = 0; k < RING_D + 14; k++) begin
            if (k % 30 == 0) burst = ($urandom_range(0, 2) == 0);
            stamp_cursor[BURST_SRC] += TIME_W'($urandom_range(0, 1000));
            post_event(src_tag[BURST_SRC], stamp_cursor[BURST_SRC]);
        end
        burst = 1'b0;

        // mid-range window
        write_window($urandom_range(1000, 50_000_000));
        run_mixed(150, 1'b0);
        // receiver holds off while events keep coming: output and input stall
        rx_hold_cycles = HOLD_CYCLES;
        run_mixed(40, 1'b1);
        // sender pauses until the block has handed out everything
        i_in_valid <= 1'b0;
        wait_drained();
        run_mixed(110, 1'b0);

        // short window: one jump expires the whole ring
        write_window($urandom_range(1, 1000));
        stamp_cursor[BURST_SRC] += 64'd1 << 40;
        post_event(src_tag[BURST_SRC], stamp_cursor[BURST_SRC]);
        run_mixed(100, 1'b0);

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("per_source_sliding_window_rate verification clean");
        end
        else begin
            $display("per_source_sliding_window_rate verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #60_000_000;
        $display("per_source_sliding_window_rate verification failed");
        $finish;
    end

endmodule

// ===== per_source_sliding_window_rate.f =====
rtl/core/pswr_pkg.sv
rtl/core/pswr_ctrl.sv
rtl/core/pswr_dp.sv
rtl/core/per_source_sliding_window_rate.sv
rtl/core/pswr_chk.sv
dv/testbench.sv
